[sv/vdn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdn_pkg
// Types and constants shared by the vertex direction normalizer modules.
// ----------------------------------------------------------------------------
package vdn_pkg;

   localparam int COORD_BITS    = 24;
   localparam int DIR_FRAC_BITS = 15;
   localparam int DIR_BITS      = DIR_FRAC_BITS + 1;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int NORM_BITS     = 16;
   localparam int SQ_BITS       = 2 * NORM_BITS;
   localparam int SUM_BITS      = SQ_BITS + 2;
   localparam int GUARD_BITS    = 14;
   localparam int RAD_BITS      = SUM_BITS + 2 * GUARD_BITS;
   localparam int ROOT_BITS     = RAD_BITS / 2;
   localparam int SREM_BITS     = ROOT_BITS + 3;
   localparam int QUO_BITS      = DIR_BITS;
   localparam int DVS_BITS      = ROOT_BITS + 1;
   localparam int POS_BITS      = $clog2(DIFF_BITS);

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_VERTEX = 2'd1;
   localparam logic [1:0] STATUS_MULTI     = 2'd2;
   localparam logic [1:0] STATUS_ZERO_LEN  = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] start_z;
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic signed [COORD_BITS-1:0] vertex_z;
      logic [3:0]                   vertex_count;
   } vdn_req_type;

   typedef struct packed {
      logic signed [DIR_BITS-1:0] dir_x;
      logic signed [DIR_BITS-1:0] dir_y;
      logic signed [DIR_BITS-1:0] dir_z;
      logic [1:0]                 status;
   } vdn_rsp_type;

   typedef struct packed {
      logic [2:0]                 neg;
      logic [1:0]                 status;
      logic [2:0][NORM_BITS-1:0]  mag;
      logic [RAD_BITS-1:0]        rad;
      logic [SREM_BITS-1:0]       rem;
      logic [ROOT_BITS-1:0]       root;
   } vdn_root_type;

   typedef struct packed {
      logic [2:0]                 neg;
      logic [1:0]                 status;
      logic [2:0][DVS_BITS-1:0]   rem;
      logic [2:0][QUO_BITS-1:0]   quo;
      logic [2:0][QUO_BITS-1:0]   nlo;
      logic [DVS_BITS-1:0]        dvs;
   } vdn_div_type;

endpackage

[sv/vdn_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdn_front
// Differences, status, common normalization, squares and their sum.
// ----------------------------------------------------------------------------
module vdn_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vdn_pkg::vdn_req_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vdn_pkg::vdn_root_type out_data
);

   logic                                   a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic                                   a_ready, b_ready, c_ready, d_ready;
   logic [2:0]                             a_neg_ff, b_neg_ff, c_neg_ff;
   logic [1:0]                             a_status_ff, b_status_ff, c_status_ff;
   logic [2:0][vdn_pkg::DIFF_BITS-1:0]     a_mag_ff, a_mag_in;
   logic [2:0]                             a_neg_in;
   logic [1:0]                             a_status_in, b_status_in;
   logic [2:0][vdn_pkg::NORM_BITS-1:0]     b_mag_ff, b_mag_in, c_mag_ff;
   logic [2:0][vdn_pkg::SQ_BITS-1:0]       c_sq_ff;
   logic [2:0][vdn_pkg::COORD_BITS-1:0]    start_pt, vertex_pt;
   logic [2:0][vdn_pkg::DIFF_BITS-1:0]     diff;
   logic [vdn_pkg::DIFF_BITS-1:0]          mag_or;
   logic [vdn_pkg::POS_BITS-1:0]           msb_pos;
   logic [vdn_pkg::SUM_BITS-1:0]           sum;
   vdn_pkg::vdn_root_type                  d_data_ff, d_data_in;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Stage A: signed differences, magnitudes and vertex-count status.
   always_comb begin
      start_pt  = {in_data.start_z, in_data.start_y, in_data.start_x};
      vertex_pt = {in_data.vertex_z, in_data.vertex_y, in_data.vertex_x};
      for (int i = 0; i < 3; i++) begin
         diff[i]     = {start_pt[i][vdn_pkg::COORD_BITS-1], start_pt[i]}
                     - {vertex_pt[i][vdn_pkg::COORD_BITS-1], vertex_pt[i]};
         a_neg_in[i] = diff[i][vdn_pkg::DIFF_BITS-1];
         a_mag_in[i] = a_neg_in[i] ? (~diff[i] + 1'b1) : diff[i];
      end
      if (in_data.vertex_count == 4'd0) begin
         a_status_in = vdn_pkg::STATUS_NO_VERTEX;
      end else if (in_data.vertex_count != 4'd1) begin
         a_status_in = vdn_pkg::STATUS_MULTI;
      end else begin
         a_status_in = vdn_pkg::STATUS_OK;
      end
   end

   // Stage B: the leading one of the OR of the magnitudes is that of the largest one,
   // so one shift brings the largest magnitude into [2^15, 2^16).
   always_comb begin
      mag_or  = a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2];
      msb_pos = '0;
      for (int k = 0; k < vdn_pkg::DIFF_BITS; k++) begin
         if (mag_or[k]) begin
            msb_pos = vdn_pkg::POS_BITS'(k);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (msb_pos >= vdn_pkg::POS_BITS'(vdn_pkg::NORM_BITS - 1)) begin
            b_mag_in[i] = vdn_pkg::NORM_BITS'(a_mag_ff[i]
                          >> (msb_pos - vdn_pkg::POS_BITS'(vdn_pkg::NORM_BITS - 1)));
         end else begin
            b_mag_in[i] = vdn_pkg::NORM_BITS'(a_mag_ff[i]
                          << (vdn_pkg::POS_BITS'(vdn_pkg::NORM_BITS - 1) - msb_pos));
         end
      end
      if (a_status_ff == vdn_pkg::STATUS_OK && mag_or == '0) begin
         b_status_in = vdn_pkg::STATUS_ZERO_LEN;
      end else begin
         b_status_in = a_status_ff;
      end
   end

   // Stage D: sum of squares, placed as the radicand with the guard bits below it.
   always_comb begin
      sum = vdn_pkg::SUM_BITS'(c_sq_ff[0]) + vdn_pkg::SUM_BITS'(c_sq_ff[1])
          + vdn_pkg::SUM_BITS'(c_sq_ff[2]);
      d_data_in.neg    = c_neg_ff;
      d_data_in.status = c_status_ff;
      d_data_in.mag    = c_mag_ff;
      d_data_in.rad    = {sum, {(2 * vdn_pkg::GUARD_BITS){1'b0}}};
      d_data_in.rem    = '0;
      d_data_in.root   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_neg_ff    <= a_neg_in;
         a_mag_ff    <= a_mag_in;
         a_status_ff <= a_status_in;
      end
      if (b_ready && a_valid_ff) begin
         b_neg_ff    <= a_neg_ff;
         b_mag_ff    <= b_mag_in;
         b_status_ff <= b_status_in;
      end
      if (c_ready && b_valid_ff) begin
         c_neg_ff    <= b_neg_ff;
         c_mag_ff    <= b_mag_ff;
         c_status_ff <= b_status_ff;
         for (int i = 0; i < 3; i++) begin
            c_sq_ff[i] <= b_mag_ff[i] * b_mag_ff[i];
         end
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

[sv/vdn_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdn_sqrt_cell
// One restoring square-root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module vdn_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vdn_pkg::vdn_root_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vdn_pkg::vdn_root_type out_data
);

   logic                          valid_ff;
   vdn_pkg::vdn_root_type         data_ff, data_in;
   logic [vdn_pkg::SREM_BITS-1:0] cur, trial;
   logic                          fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      cur     = {in_data.rem[vdn_pkg::SREM_BITS-3:0],
                 in_data.rad[vdn_pkg::RAD_BITS-1 -: 2]};
      trial   = {1'b0, in_data.root, 2'b01};
      fits    = cur >= trial;
      data_in = in_data;
      data_in.rem  = fits ? (cur - trial) : cur;
      data_in.root = {in_data.root[vdn_pkg::ROOT_BITS-2:0], fits};
      data_in.rad  = {in_data.rad[vdn_pkg::RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/vdn_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdn_div_cell
// One restoring division step for all three lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module vdn_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  vdn_pkg::vdn_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vdn_pkg::vdn_div_type out_data
);

   logic                         valid_ff;
   vdn_pkg::vdn_div_type         data_ff, data_in;
   logic [vdn_pkg::DVS_BITS:0]   cur, diff;
   logic                         fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      cur     = '0;
      diff    = '0;
      fits    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         cur  = {in_data.rem[i], in_data.nlo[i][vdn_pkg::QUO_BITS-1]};
         fits = cur >= {1'b0, in_data.dvs};
         diff = cur - {1'b0, in_data.dvs};
         data_in.rem[i] = fits ? diff[vdn_pkg::DVS_BITS-1:0] : cur[vdn_pkg::DVS_BITS-1:0];
         data_in.quo[i] = {in_data.quo[i][vdn_pkg::QUO_BITS-2:0], fits};
         data_in.nlo[i] = {in_data.nlo[i][vdn_pkg::QUO_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/vertex_direction_normalizer.sv]
`timescale 1ns / 1ps
// Pipeline: 4 front stages, 31 square-root cells, 1 divider setup stage, 16 divider
// cells and 1 output stage lie between an accepted request and its response.
// Throughput: one transaction per cycle while rsp_stall is low; every cell holds one item
// and moves it on whenever the next cell is empty or moving, so stalls only fill bubbles.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// vertex_direction_normalizer
// Unit direction cosines from a vertex to a start point, signed Q1.15.
// ----------------------------------------------------------------------------
module vertex_direction_normalizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vdn_pkg::vdn_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vdn_pkg::vdn_rsp_type rsp_data
);

   localparam int SQRT_CELLS = vdn_pkg::ROOT_BITS;
   localparam int DIV_CELLS  = vdn_pkg::QUO_BITS;

   logic                  front_ready;
   logic                  sq_valid [SQRT_CELLS+1];
   logic                  sq_ready [SQRT_CELLS+1];
   vdn_pkg::vdn_root_type sq_data  [SQRT_CELLS+1];
   logic                  dv_valid [DIV_CELLS+1];
   logic                  dv_ready [DIV_CELLS+1];
   vdn_pkg::vdn_div_type  dv_data  [DIV_CELLS+1];
   logic                  setup_valid_ff;
   vdn_pkg::vdn_div_type  setup_ff, setup_in;
   logic                  rsp_valid_ff, out_ready;
   vdn_pkg::vdn_rsp_type  rsp_ff, rsp_in;
   logic [vdn_pkg::ROOT_BITS-1:0] root;
   logic [2:0][vdn_pkg::DIR_BITS-1:0] dir;
   logic [vdn_pkg::QUO_BITS-1:0] sat;

   assign req_stall = !front_ready;

   vdn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_data  (sq_data[0])
   );

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      vdn_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[g]),
         .in_ready  (sq_ready[g]),
         .in_data   (sq_data[g]),
         .out_valid (sq_valid[g+1]),
         .out_ready (sq_ready[g+1]),
         .out_data  (sq_data[g+1])
      );
   end

   // Divider setup: numerator is mag * 2^(frac+guard+1) + root, divisor is 2 * root.
   // The quotient fits in QUO_BITS, so the high numerator part is already below the divisor.
   assign sq_ready[SQRT_CELLS] = !setup_valid_ff || dv_ready[0];
   assign root = sq_data[SQRT_CELLS].root;

   always_comb begin
      setup_in.neg    = sq_data[SQRT_CELLS].neg;
      setup_in.status = sq_data[SQRT_CELLS].status;
      setup_in.dvs    = {root, 1'b0};
      for (int i = 0; i < 3; i++) begin
         setup_in.rem[i] = vdn_pkg::DVS_BITS'(
            ({sq_data[SQRT_CELLS].mag[i], {vdn_pkg::GUARD_BITS{1'b0}}})
            + (root >> vdn_pkg::QUO_BITS));
         setup_in.quo[i] = '0;
         setup_in.nlo[i] = root[vdn_pkg::QUO_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else if (sq_ready[SQRT_CELLS]) begin
         setup_valid_ff <= sq_valid[SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (sq_ready[SQRT_CELLS] && sq_valid[SQRT_CELLS]) begin
         setup_ff <= setup_in;
      end
   end

   assign dv_valid[0] = setup_valid_ff;
   assign dv_data[0]  = setup_ff;

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      vdn_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_ready  (dv_ready[g]),
         .in_data   (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_ready (dv_ready[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   // Output stage: saturate, apply the sign, and zero everything but good transactions.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign dv_ready[DIV_CELLS] = out_ready;

   always_comb begin
      sat = '0;
      for (int i = 0; i < 3; i++) begin
         sat = dv_data[DIV_CELLS].quo[i][vdn_pkg::QUO_BITS-1]
             ? {1'b0, {(vdn_pkg::QUO_BITS-1){1'b1}}} : dv_data[DIV_CELLS].quo[i];
         if (dv_data[DIV_CELLS].status != vdn_pkg::STATUS_OK) begin
            dir[i] = '0;
         end else if (dv_data[DIV_CELLS].neg[i]) begin
            dir[i] = ~sat + 1'b1;
         end else begin
            dir[i] = sat;
         end
      end
      rsp_in.dir_x  = dir[0];
      rsp_in.dir_y  = dir[1];
      rsp_in.dir_z  = dir[2];
      rsp_in.status = dv_data[DIV_CELLS].status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_valid[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && dv_valid[DIV_CELLS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != vdn_pkg::STATUS_OK |->
      rsp_data.dir_x == '0 && rsp_data.dir_y == '0 && rsp_data.dir_z == '0)
      else $error("non-ok response carries a nonzero direction");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == vdn_pkg::STATUS_OK |->
      rsp_data.dir_x != '0 || rsp_data.dir_y != '0 || rsp_data.dir_z != '0)
      else $error("ok response carries a zero direction");

   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.dir_x != {1'b1, {(vdn_pkg::DIR_BITS-1){1'b0}}}
                 && rsp_data.dir_y != {1'b1, {(vdn_pkg::DIR_BITS-1){1'b0}}}
                 && rsp_data.dir_z != {1'b1, {(vdn_pkg::DIR_BITS-1){1'b0}}})
      else $error("direction cosine outside saturation range");
`endif

endmodule
